// File: rtl/mple_pkg.sv
`default_nettype none
package mple_pkg;

    localparam int unsigned MAX_ENTRIES_DEF = 32;

    // Input commands
    localparam logic [2:0] CMD_ADD       = 3'd0;
    localparam logic [2:0] CMD_REMOVE    = 3'd1;
    localparam logic [2:0] CMD_ADD_CODE  = 3'd2;
    localparam logic [2:0] CMD_REM_CODE  = 3'd3;
    localparam logic [2:0] CMD_APPLY     = 3'd4;
    localparam logic [2:0] CMD_READ_DATA = 3'd5;

    // Entry kinds
    localparam logic [1:0] KIND_ENABLE = 2'd0;
    localparam logic [1:0] KIND_BYTE   = 2'd1;
    localparam logic [1:0] KIND_WORD   = 2'd2;
    localparam logic [1:0] KIND_LONG   = 2'd3;

    // Result kinds
    localparam logic [2:0] OUT_BYTE   = 3'd0;
    localparam logic [2:0] OUT_WORD   = 3'd1;
    localparam logic [2:0] OUT_LONG   = 3'd2;
    localparam logic [2:0] OUT_READ   = 3'd3;
    localparam logic [2:0] OUT_STATUS = 3'd4;

    // Status codes
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND   = 3'd1;
    localparam logic [2:0] ST_UNKNOWN     = 3'd2;
    localparam logic [2:0] ST_FULL        = 3'd3;
    localparam logic [2:0] ST_NOT_WAITING = 3'd4;

    // Code word nibbles
    localparam logic [3:0] CODE_WORD   = 4'h1;
    localparam logic [3:0] CODE_BYTE   = 4'h3;
    localparam logic [3:0] CODE_ENABLE = 4'hD;
    localparam logic [31:0] CODE_ADDR_MASK = 32'h0FFF_FFFF;

    // Controller to datapath commands
    typedef struct packed {
        logic latch_in;   // capture the input transaction
        logic wr_tail;    // write operand at tail, count up
        logic scan_clr;   // index := 0
        logic scan_inc;   // index := index + 1
        logic shift;      // entry[idx-1] := entry[idx]
        logic dec_cnt;    // count down
        logic set_idx_wp; // index := walk position + 1
        logic set_wp;     // walk position := index
    } mple_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic [2:0] cmd;
        logic       code_ok;
        logic       full;
        logic       idx_end;   // index >= count
        logic       match;     // entry at index equals operand
        logic [1:0] ent_kind;  // kind of entry at index
        logic       wp_valid;  // walk position < count
        logic       rd_match;  // entry at walk position equals read word
    } mple_sts_t;

endpackage
`default_nettype wire

// File: rtl/mple_datapath.sv
`default_nettype none
module mple_datapath
    import mple_pkg::*;
#(
    parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int unsigned IW = $clog2(MAX_ENTRIES),
    parameter int unsigned CW = $clog2(MAX_ENTRIES + 1)
)(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire mple_cmd_t   cmd,
    input  wire logic [2:0]  in_command,
    input  wire logic [1:0]  in_kind,
    input  wire logic [31:0] in_address,
    input  wire logic [31:0] in_value,
    input  wire logic [15:0] in_read_word,
    output mple_sts_t        sts,
    output logic [1:0]       idx_kind,
    output logic [31:0]      idx_address,
    output logic [31:0]      idx_value,
    output logic [CW-1:0]    count
);

    logic [1:0]  kinds_mem [MAX_ENTRIES];
    logic [31:0] addr_mem  [MAX_ENTRIES];
    logic [31:0] val_mem   [MAX_ENTRIES];

    logic [2:0]    cmd_reg;
    logic [1:0]    op_kind_reg;
    logic [31:0]   op_addr_reg, op_val_reg;
    logic          code_ok_reg;
    logic [15:0]   rd_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [IW-1:0] wp_reg;

    // Entry read back, registered, in the cycle after its address
    logic [1:0]    ent_kind_reg;
    logic [31:0]   ent_addr_reg, ent_val_reg;

    logic [IW-1:0] ia, ia_m1, raddr;
    logic [CW-1:0] idx_p1;
    logic          code_ok;
    logic [1:0]    code_kind;

    assign ia     = idx_reg[IW-1:0];
    assign ia_m1  = ia - IW'(1);
    assign idx_p1 = idx_reg + CW'(1);

    // Code word decode
    always_comb
    begin
        code_ok   = 1'b1;
        code_kind = KIND_ENABLE;
        unique case (in_address[31:28])
            CODE_WORD:   code_kind = KIND_WORD;
            CODE_BYTE:   code_kind = KIND_BYTE;
            CODE_ENABLE: code_kind = KIND_ENABLE;
            default:     code_ok = 1'b0;
        endcase
    end

    // Operand capture
    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            cmd_reg     <= in_command;
            rd_reg      <= in_read_word;
            code_ok_reg <= code_ok;
            if (in_command == CMD_ADD_CODE || in_command == CMD_REM_CODE)
            begin
                op_kind_reg <= code_kind;
                op_addr_reg <= in_address & CODE_ADDR_MASK;
                op_val_reg  <= {16'd0, in_value[15:0]};
            end
            else
            begin
                op_kind_reg <= in_kind;
                op_addr_reg <= in_address;
                op_val_reg  <= in_value;
            end
        end
    end

    // Entry store: tail write, or move the entry at index up by one place
    always_ff @(posedge clk)
    begin
        if (cmd.wr_tail)
        begin
            kinds_mem[cnt_reg[IW-1:0]] <= op_kind_reg;
            addr_mem[cnt_reg[IW-1:0]]  <= op_addr_reg;
            val_mem[cnt_reg[IW-1:0]]   <= op_val_reg;
        end
        else if (cmd.shift)
        begin
            kinds_mem[ia_m1] <= ent_kind_reg;
            addr_mem[ia_m1]  <= ent_addr_reg;
            val_mem[ia_m1]   <= ent_val_reg;
        end
    end

    // Read ahead at the next index, or at the walk position for read data
    assign raddr = (cmd.latch_in && in_command == CMD_READ_DATA) ? wp_reg
                                                                 : idx_next[IW-1:0];

    always_ff @(posedge clk)
    begin
        ent_kind_reg <= kinds_mem[raddr];
        ent_addr_reg <= addr_mem[raddr];
        ent_val_reg  <= val_mem[raddr];
    end

    // Count and index
    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.wr_tail)
            cnt_next = cnt_reg + CW'(1);
        else if (cmd.dec_cnt)
            cnt_next = cnt_reg - CW'(1);
        idx_next = idx_reg;
        priority if (cmd.scan_clr)
            idx_next = '0;
        else if (cmd.set_idx_wp)
            idx_next = CW'(wp_reg) + CW'(1);
        else if (cmd.scan_inc)
            idx_next = idx_p1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            idx_reg <= '0;
            wp_reg  <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
            if (cmd.set_wp)
                wp_reg <= ia;
        end
    end

    assign idx_kind    = ent_kind_reg;
    assign idx_address = ent_addr_reg;
    assign idx_value   = ent_val_reg;
    assign count       = cnt_reg;

    always_comb
    begin
        sts.cmd      = cmd_reg;
        sts.code_ok  = (cmd_reg == CMD_ADD_CODE || cmd_reg == CMD_REM_CODE)
                       ? code_ok_reg : 1'b1;
        sts.full     = (cnt_reg >= CW'(MAX_ENTRIES));
        sts.idx_end  = (idx_reg >= cnt_reg);
        sts.match    = (ent_kind_reg == op_kind_reg) && (ent_addr_reg == op_addr_reg)
                       && (ent_val_reg == op_val_reg);
        sts.ent_kind = ent_kind_reg;
        sts.wp_valid = (CW'(wp_reg) < cnt_reg);
        sts.rd_match = (ent_val_reg == {16'd0, rd_reg});
    end

endmodule
`default_nettype wire

// File: rtl/mple_ctrl.sv
`default_nettype none
module mple_ctrl
    import mple_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_fire,
    input  wire logic [2:0] in_command,
    input  wire logic       out_free,   // output register empty or draining
    input  wire mple_sts_t  sts,
    output mple_cmd_t       cmd,
    output logic            in_ready,
    output logic            emit,
    output logic            emit_entry, // emit entry at index, else status
    output logic [2:0]      emit_status,
    output logic            emit_last
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DECODE = 6'b000010,
        S_SEARCH = 6'b000100,
        S_SHIFT  = 6'b001000,
        S_WALK   = 6'b010000,
        S_DONE   = 6'b100000
    } state_t;

    state_t     state_reg, state_next;
    logic       await_reg, await_next;
    logic [2:0] st_reg, st_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        await_next  = await_reg;
        st_next     = st_reg;
        cmd         = '0;
        emit        = 1'b0;
        emit_entry  = 1'b0;
        emit_status = st_reg;
        emit_last   = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.latch_in = 1'b1;
                    cmd.scan_clr = 1'b1;
                    if (in_command != CMD_READ_DATA && in_command <= CMD_APPLY)
                        await_next = 1'b0;
                    if (in_command <= CMD_READ_DATA)
                        state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_DONE;
                st_next    = ST_OK;
                priority if (!sts.code_ok)
                    st_next = ST_UNKNOWN;
                else if (sts.cmd == CMD_ADD || sts.cmd == CMD_ADD_CODE)
                begin
                    if (sts.full)
                        st_next = ST_FULL;
                    else
                        cmd.wr_tail = 1'b1;
                end
                else if (sts.cmd == CMD_REMOVE || sts.cmd == CMD_REM_CODE)
                    state_next = S_SEARCH;
                else if (sts.cmd == CMD_APPLY)
                    state_next = S_WALK;
                else if (!await_reg || !sts.wp_valid)
                    st_next = ST_NOT_WAITING;
                else if (sts.rd_match)
                begin
                    await_next     = 1'b0;
                    cmd.set_idx_wp = 1'b1;
                    state_next     = S_WALK;
                end
                else
                    await_next = 1'b0;
            end
            S_SEARCH:
            begin
                priority if (sts.idx_end)
                begin
                    st_next    = ST_NOT_FOUND;
                    state_next = S_DONE;
                end
                else if (sts.match)
                begin
                    // step past the match; later entries then move up one by one
                    cmd.scan_inc = 1'b1;
                    state_next   = S_SHIFT;
                end
                else
                    cmd.scan_inc = 1'b1;
            end
            S_SHIFT:
            begin
                if (sts.idx_end)
                begin
                    cmd.dec_cnt = 1'b1;
                    st_next     = ST_OK;
                    state_next  = S_DONE;
                end
                else
                begin
                    cmd.shift    = 1'b1;
                    cmd.scan_inc = 1'b1;
                end
            end
            S_WALK:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    priority if (sts.idx_end)
                    begin
                        emit_status = ST_OK;
                        state_next  = S_IDLE;
                    end
                    else if (sts.ent_kind == KIND_ENABLE)
                    begin
                        emit_entry = 1'b1;
                        cmd.set_wp = 1'b1;
                        await_next = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        emit_entry   = 1'b1;
                        emit_last    = 1'b0;
                        cmd.scan_inc = 1'b1;
                    end
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            await_reg <= 1'b0;
            st_reg    <= ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            await_reg <= await_next;
            st_reg    <= st_next;
        end
    end

endmodule
`default_nettype wire

// File: rtl/memory_patch_list_engine.sv
`default_nettype none
// Patch list engine. Holds up to MAX_ENTRIES patch entries and takes one
// command transaction at a time. Remove searches up to the match, and
// each later entry then moves up one place per cycle; apply emits one
// result per cycle, while the output is not stalled, from a walk of the
// entry store. Results leave through a single output register; the next
// command is taken once the last result of the current one has been
// loaded into it.
module memory_patch_list_engine
    import mple_pkg::*;
#(
    parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF
)(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // command[2:0], entry_kind[4:3], address[36:5], value[68:37],
    // read_word[84:69], zero fill
    input  wire logic [87:0]  s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // kind[2:0], mem_address[34:3], write_data[66:35], status[69:67],
    // entry_count[75:70], zero fill
    output logic [79:0]       m_tdata,
    output logic              m_tlast
);

    localparam int unsigned IW = $clog2(MAX_ENTRIES);
    localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);

    mple_cmd_t     cmd;
    mple_sts_t     sts;
    logic          in_fire, out_free, emit, emit_entry, emit_last;
    logic [2:0]    emit_status;
    logic [1:0]    idx_kind;
    logic [31:0]   idx_address, idx_value;
    logic [CW-1:0] count;

    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !m_tvalid || m_tready;

    mple_datapath #(.MAX_ENTRIES(MAX_ENTRIES), .IW(IW), .CW(CW)) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .in_command   (s_tdata[2:0]),
        .in_kind      (s_tdata[4:3]),
        .in_address   (s_tdata[36:5]),
        .in_value     (s_tdata[68:37]),
        .in_read_word (s_tdata[84:69]),
        .sts          (sts),
        .idx_kind     (idx_kind),
        .idx_address  (idx_address),
        .idx_value    (idx_value),
        .count        (count)
    );

    mple_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_fire     (in_fire),
        .in_command  (s_tdata[2:0]),
        .out_free    (out_free),
        .sts         (sts),
        .cmd         (cmd),
        .in_ready    (s_tready),
        .emit        (emit),
        .emit_entry  (emit_entry),
        .emit_status (emit_status),
        .emit_last   (emit_last)
    );

    // Result formatting
    logic [2:0]  r_kind;
    logic [31:0] r_addr, r_data;
    logic [2:0]  r_status;
    always_comb
    begin
        r_kind   = OUT_STATUS;
        r_addr   = '0;
        r_data   = '0;
        r_status = emit_status;
        if (emit_entry)
        begin
            r_addr   = idx_address;
            r_status = ST_OK;
            unique case (idx_kind)
                KIND_ENABLE: r_kind = OUT_READ;
                KIND_BYTE:
                begin
                    r_kind = OUT_BYTE;
                    r_data = {24'd0, idx_value[7:0]};
                end
                KIND_WORD:
                begin
                    r_kind = OUT_WORD;
                    r_data = {16'd0, idx_value[15:0]};
                end
                default:
                begin
                    r_kind = OUT_LONG;
                    r_data = idx_value;
                end
            endcase
        end
    end

    // Output register
    logic        out_valid_reg;
    logic [79:0] out_data_reg;
    logic        out_last_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_data_reg <= {4'd0, 6'(count), r_status, r_data, r_addr, r_kind};
            out_last_reg <= emit_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    // Checks
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count <= CW'(MAX_ENTRIES))
        else $error("entry count above capacity");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !emit)
        else $error("result loaded over a stalled one");

    a_busy_no_take: assert property (@(posedge clk) disable iff (!rst_n)
        emit && !emit_last |=> !s_tready)
        else $error("command taken mid-walk");

endmodule
`default_nettype wire

// File: tb/memory_patch_list_checker.sv
`default_nettype none
module memory_patch_list_checker
    import mple_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [87:0] s_tdata,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [79:0] m_tdata,
    input  wire logic        m_tlast,
    output int               fail_count,
    output int               pending_results
);

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] mem_address;
        logic [31:0] write_data;
        logic [2:0]  status;
        logic [5:0]  entry_count;
        logic        last;
    } patch_result_t;

    // Shadow copy of the patch list
    logic [1:0]  shadow_kind [MAX_ENTRIES_DEF];
    logic [31:0] shadow_addr [MAX_ENTRIES_DEF];
    logic [31:0] shadow_value[MAX_ENTRIES_DEF];
    int unsigned shadow_count;
    int unsigned walk_pos;
    bit          awaiting;

    patch_result_t expected_results[$];
    patch_result_t step_results[$];

    assign pending_results = expected_results.size();

    function automatic void push_result(logic [2:0] k, logic [31:0] a, logic [31:0] d,
                                        logic [2:0] st);
        patch_result_t r;
        r.kind        = k;
        r.mem_address = a;
        r.write_data  = d;
        r.status      = st;
        r.entry_count = shadow_count[5:0];
        r.last        = 1'b0;
        step_results.push_back(r);
    endfunction

    function automatic logic [2:0] list_add(logic [1:0] k, logic [31:0] a, logic [31:0] v);
        if (shadow_count >= MAX_ENTRIES_DEF)
            return ST_FULL;
        shadow_kind[shadow_count]  = k;
        shadow_addr[shadow_count]  = a;
        shadow_value[shadow_count] = v;
        shadow_count++;
        return ST_OK;
    endfunction

    function automatic logic [2:0] list_remove(logic [1:0] k, logic [31:0] a,
                                               logic [31:0] v);
        int unsigned i;
        i = 0;
        while (i < shadow_count && !(shadow_kind[i] == k && shadow_addr[i] == a &&
                                     shadow_value[i] == v))
            i++;
        if (i >= shadow_count)
            return ST_NOT_FOUND;
        for (int unsigned j = i; j + 1 < shadow_count; j++)
        begin
            shadow_kind[j]  = shadow_kind[j+1];
            shadow_addr[j]  = shadow_addr[j+1];
            shadow_value[j] = shadow_value[j+1];
        end
        shadow_count--;
        return ST_OK;
    endfunction

    // Walk from a position until an enable entry or the end of the list
    function automatic void walk_list(int unsigned start);
        for (int unsigned i = start; i < shadow_count; i++)
        begin
            case (shadow_kind[i])
                KIND_ENABLE:
                begin
                    walk_pos = i;
                    awaiting = 1'b1;
                    push_result(OUT_READ, shadow_addr[i], 32'd0, ST_OK);
                    return;
                end
                KIND_BYTE: push_result(OUT_BYTE, shadow_addr[i], {24'd0, shadow_value[i][7:0]},
                                       ST_OK);
                KIND_WORD: push_result(OUT_WORD, shadow_addr[i],
                                       {16'd0, shadow_value[i][15:0]}, ST_OK);
                default:   push_result(OUT_LONG, shadow_addr[i], shadow_value[i], ST_OK);
            endcase
        end
        awaiting = 1'b0;
        walk_pos = 0;
        push_result(OUT_STATUS, 32'd0, 32'd0, ST_OK);
    endfunction

    function automatic void predict_command(logic [87:0] d);
        logic [2:0]  cmd;
        logic [1:0]  k;
        logic [31:0] a;
        logic [31:0] v;
        logic [15:0] rw;
        logic [2:0]  st;
        bit          ok;
        cmd = d[2:0];
        k   = d[4:3];
        a   = d[36:5];
        v   = d[68:37];
        rw  = d[84:69];
        step_results.delete();
        case (cmd)
            CMD_ADD, CMD_REMOVE:
            begin
                awaiting = 1'b0;
                st = (cmd == CMD_ADD) ? list_add(k, a, v) : list_remove(k, a, v);
                push_result(OUT_STATUS, 32'd0, 32'd0, st);
            end
            CMD_ADD_CODE, CMD_REM_CODE:
            begin
                awaiting = 1'b0;
                ok = 1'b1;
                case (a[31:28])
                    CODE_WORD:   k = KIND_WORD;
                    CODE_BYTE:   k = KIND_BYTE;
                    CODE_ENABLE: k = KIND_ENABLE;
                    default:     ok = 1'b0;
                endcase
                if (!ok)
                    st = ST_UNKNOWN;
                else if (cmd == CMD_ADD_CODE)
                    st = list_add(k, a & CODE_ADDR_MASK, {16'd0, v[15:0]});
                else
                    st = list_remove(k, a & CODE_ADDR_MASK, {16'd0, v[15:0]});
                push_result(OUT_STATUS, 32'd0, 32'd0, st);
            end
            CMD_APPLY:
            begin
                awaiting = 1'b0;
                walk_list(0);
            end
            CMD_READ_DATA:
            begin
                if (!awaiting || walk_pos >= shadow_count)
                    push_result(OUT_STATUS, 32'd0, 32'd0, ST_NOT_WAITING);
                else if (shadow_value[walk_pos] == {16'd0, rw})
                begin
                    awaiting = 1'b0;
                    walk_list(walk_pos + 1);
                end
                else
                begin
                    awaiting = 1'b0;
                    walk_pos = 0;
                    push_result(OUT_STATUS, 32'd0, 32'd0, ST_OK);
                end
            end
            default: ;
        endcase
        if (step_results.size() > 0)
            step_results[step_results.size()-1].last = 1'b1;
        foreach (step_results[i])
            expected_results.push_back(step_results[i]);
    endfunction

    // Observe both channels and compare
    always @(posedge clk or negedge rst_n)
    begin
        patch_result_t got;
        patch_result_t exp_r;
        if (!rst_n)
        begin
            shadow_count = 0;
            walk_pos     = 0;
            awaiting     = 1'b0;
            fail_count   = 0;
            expected_results.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = {m_tdata[2:0], m_tdata[34:3], m_tdata[66:35], m_tdata[69:67],
                       m_tdata[75:70], m_tlast};
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result transaction %h", $time, got);
                    fail_count++;
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (got.kind !== exp_r.kind)
                        $display("%0t: kind expected %0d actual %0d", $time, exp_r.kind,
                                 got.kind);
                    if (got.mem_address !== exp_r.mem_address)
                        $display("%0t: mem_address expected %h actual %h", $time,
                                 exp_r.mem_address, got.mem_address);
                    if (got.write_data !== exp_r.write_data)
                        $display("%0t: write_data expected %h actual %h", $time,
                                 exp_r.write_data, got.write_data);
                    if (got.status !== exp_r.status)
                        $display("%0t: status expected %0d actual %0d", $time,
                                 exp_r.status, got.status);
                    if (got.entry_count !== exp_r.entry_count)
                        $display("%0t: entry_count expected %0d actual %0d", $time,
                                 exp_r.entry_count, got.entry_count);
                    if (got.last !== exp_r.last)
                        $display("%0t: last expected %0d actual %0d", $time,
                                 exp_r.last, got.last);
                    if (got !== exp_r)
                        fail_count++;
                end
            end
            if (s_tvalid && s_tready)
                predict_command(s_tdata);
        end
    end

endmodule
`default_nettype wire

// File: tb/tb_memory_patch_list_engine.sv
`default_nettype none
module tb_memory_patch_list_engine
    import mple_pkg::*;
();

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [87:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;
    logic        m_tlast;
    int          fail_count;
    int          pending_results;
    int          cycle_count;
    int          hold_cycles;
    bit          calm_mode;

    // Remembered list contents so removes can hit real entries
    logic [1:0]  known_kind [$];
    logic [31:0] known_addr [$];
    logic [31:0] known_value[$];

    memory_patch_list_engine i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    memory_patch_list_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tlast         (m_tlast),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Receiver: random stalls, one long hold-off
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            m_tready    <= 1'b0;
        end
        else
            m_tready <= calm_mode || ($urandom_range(99) >= 8);
    end

    // Timeout
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000)
        begin
            $display("FAIL memory_patch_list_engine");
            $finish;
        end
    end

    // Valid stays high after a transaction; a random pause in the next call or a drain wait drops it
    task automatic send_command(logic [2:0] cmd, logic [1:0] k, logic [31:0] a,
                                logic [31:0] v, logic [15:0] rw);
        while (!calm_mode && $urandom_range(99) < 8)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'd0, rw, v, a, k, cmd};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
    endtask

    function automatic logic [31:0] random_value();
        case ($urandom_range(3))
            0: return $urandom_range(15);
            1: return $urandom_range(65535);
            2: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // One random command, biased towards sensible sequences
    task automatic random_command();
        int unsigned sel;
        int unsigned idx;
        logic [1:0]  k;
        logic [31:0] a;
        logic [31:0] v;
        logic [3:0]  nib;
        sel = $urandom_range(99);
        k   = 2'($urandom_range(3));
        a   = $urandom;
        v   = random_value();
        if (sel < 30)
        begin
            send_command(CMD_ADD, k, a, v, 16'($urandom));
            known_kind.push_back(k);
            known_addr.push_back(a);
            known_value.push_back(v);
        end
        else if (sel < 45)
        begin
            if (known_kind.size() > 0 && $urandom_range(3) != 0)
            begin
                idx = $urandom_range(known_kind.size() - 1);
                send_command(CMD_REMOVE, known_kind[idx], known_addr[idx],
                             known_value[idx], 16'($urandom));
            end
            else
                send_command(CMD_REMOVE, k, a, v, 16'($urandom));
        end
        else if (sel < 60)
        begin
            case ($urandom_range(4))
                0: nib = CODE_WORD;
                1: nib = CODE_BYTE;
                2, 3: nib = CODE_ENABLE;
                default: nib = 4'($urandom);
            endcase
            send_command(($urandom_range(2) == 0) ? CMD_REM_CODE : CMD_ADD_CODE, k,
                         {nib, a[27:0]}, v, 16'($urandom));
        end
        else if (sel < 75)
            send_command(CMD_APPLY, k, a, v, 16'($urandom));
        else if (sel < 97)
        begin
            // read data: value usually from one remembered entry, sent as the read word half the time
            if (known_value.size() > 0 && $urandom_range(2) != 0)
                v = known_value[$urandom_range(known_value.size() - 1)];
            send_command(CMD_READ_DATA, k, a, v,
                         ($urandom_range(1) == 0) ? v[15:0] : 16'($urandom));
        end
        else
            send_command(3'($urandom_range(7, 6)), k, a, v, 16'($urandom));
    endtask

    initial
    begin
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        m_tready    = 1'b0;
        hold_cycles = 0;
        calm_mode   = 1'b0;
        cycle_count = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty list cases, extremes, every command
        send_command(CMD_REMOVE, KIND_LONG, 32'd0, 32'd0, 16'd0);
        send_command(CMD_REM_CODE, KIND_ENABLE, 32'h1000_0000, 32'd0, 16'd0);
        send_command(CMD_READ_DATA, KIND_ENABLE, 32'd0, 32'd0, 16'hFFFF);
        send_command(CMD_APPLY, KIND_ENABLE, 32'd0, 32'd0, 16'd0);
        send_command(CMD_ADD, KIND_BYTE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd0);
        send_command(CMD_ADD, KIND_WORD, 32'h0000_0000, 32'hFFFF_FFFF, 16'd0);
        send_command(CMD_ADD, KIND_LONG, 32'h8000_0001, 32'hFFFF_FFFF, 16'd0);
        send_command(CMD_ADD_CODE, KIND_LONG, 32'hD123_4567, 32'hABCD_1234, 16'd0);
        send_command(CMD_ADD_CODE, KIND_LONG, 32'h3FFF_FFFF, 32'hFFFF_00AA, 16'd0);
        send_command(CMD_ADD_CODE, KIND_LONG, 32'h1000_0002, 32'h0000_BEEF, 16'd0);
        send_command(CMD_ADD_CODE, KIND_LONG, 32'h7000_0000, 32'd0, 16'd0);
        send_command(CMD_APPLY, KIND_ENABLE, 32'd0, 32'd0, 16'd0);
        send_command(CMD_READ_DATA, KIND_ENABLE, 32'd0, 32'd0, 16'h1234);
        send_command(CMD_APPLY, KIND_ENABLE, 32'd0, 32'd0, 16'd0);
        send_command(CMD_READ_DATA, KIND_ENABLE, 32'd0, 32'd0, 16'h0000);
        send_command(CMD_READ_DATA, KIND_ENABLE, 32'd0, 32'd0, 16'h1234);
        send_command(CMD_APPLY, KIND_ENABLE, 32'd0, 32'd0, 16'd0);
        send_command(CMD_APPLY, KIND_ENABLE, 32'd0, 32'd0, 16'd0);
        send_command(CMD_REM_CODE, KIND_LONG, 32'hD123_4567, 32'h0000_1234, 16'd0);
        send_command(CMD_REMOVE, KIND_BYTE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd0);
        send_command(3'd6, KIND_LONG, 32'd0, 32'd0, 16'd0);
        send_command(3'd7, KIND_LONG, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);

        // Fill to the limit and beyond, under a long receiver hold-off
        hold_cycles <= 300;
        for (int i = 0; i < 36; i++)
            send_command(CMD_ADD, 2'($urandom_range(3)), $urandom, random_value(), 16'd0);
        send_command(CMD_ADD_CODE, KIND_LONG, 32'h1000_0010, 32'd5, 16'd0);
        send_command(CMD_APPLY, KIND_ENABLE, 32'd0, 32'd0, 16'd0);

        // Sender pause until all results are back
        wait_results_drained();

        // Removes on a full list, mostly with no match
        for (int i = 0; i < 34; i++)
            send_command(CMD_REMOVE, KIND_LONG, 32'd0, 32'd0, 16'd0);

        // Random part, with one calm stretch
        for (int i = 0; i < 216; i++)
        begin
            calm_mode = (i >= 100 && i < 150);
            random_command();
        end
        calm_mode = 1'b0;

        wait_results_drained();
        repeat (100) @(posedge clk);
        if (fail_count == 0)
            $display("PASS memory_patch_list_engine");
        else
            $display("FAIL memory_patch_list_engine");
        $finish;
    end

endmodule
`default_nettype wire
